// File: sv/positional_list_insert_delete_assert.svh
// Assertion macros shared by the checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PLID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Types and codes shared by the positional list modules.
// ----------------------------------------------------------------------------
package pli_pkg;
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         position;
		logic signed [31:0] value;
	} pli_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [7:0]         list_count;
	} pli_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_SHIFT, S_READ, S_DONE
	} pli_state_t;

	// Memory port command from the sequencer to the element store.
	typedef struct packed {
		logic        rd_en;
		logic [7:0]  rd_addr;
		logic        wr_en;
		logic [7:0]  wr_addr;
		logic [31:0] wr_data;
	} pli_mem_cmd_t;
endpackage

// File: sv/pli_mem.sv
// ----------------------------------------------------------------------------
// pli_mem
// Element store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pli_mem #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  pli_pkg::pli_mem_cmd_t cmd,
	output logic [31:0]          rd_data
);
	import pli_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
		if (cmd.rd_en)
			rd_data <= mem[cmd.rd_addr[AW-1:0]];
	end
endmodule

// File: sv/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed 32-bit values with insert, delete and read by position.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; exactly one result
// beat follows, on result for one cycle with done high, and it cannot be stalled.
// The elements live in a single-port-read, single-port-write memory, so an insert
// or delete moves one entry at a time: read it in S_RD, then write it back one
// slot over in S_SHIFT. Busy stays high from the accepting edge through the
// result cycle. An insert at position p shifts count-p+1 entries and a delete
// shifts count-p entries; a read passes S_RD, S_READ and S_DONE, and a rejected
// request S_RD and S_DONE. The next request can be accepted in the cycle after
// the result beat. The list is empty after reset; no clearing pass is needed.
module positional_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pli_pkg::pli_req_t req,
	output logic              busy,
	output logic              done,
	output pli_pkg::pli_rsp_t result
);
	import pli_pkg::*;

	pli_state_t   state_q, state_d;
	logic [7:0]   count_q;
	logic [7:0]   k_q;          // current shift index
	pli_req_t     req_q;
	pli_rsp_t     rsp_q;
	pli_mem_cmd_t cmd;
	logic [31:0]  rd_data;
	logic [7:0]   pos_m1;
	logic         pos_ok_ins, pos_ok_other;

	pli_mem #(.DEPTH(DEPTH)) u_mem (.clk(clk), .cmd(cmd), .rd_data(rd_data));

	assign pos_m1       = req_q.position - 8'd1;
	assign pos_ok_ins   = (req_q.position != 8'd0) &&
		({1'b0, req_q.position} <= {1'b0, count_q} + 9'd1);
	assign pos_ok_other = (req_q.position != 8'd0) && (req_q.position <= count_q);
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign result = rsp_q;

	// Sequencer. Insert walks k from count down to pos, copying k-1 into k;
	// delete walks k from pos-1 up, copying k+1 into k.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: if (start) state_d = S_RD;
			S_RD: begin
				// Decide the outcome; issue the next shift read, or the final insert write.
				state_d = S_DONE;
				if (req_q.req_type == REQ_READ && pos_ok_other) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = pos_m1;
					state_d     = S_READ;
				end else if (req_q.req_type == REQ_INSERT && pos_ok_ins &&
						count_q < 8'(DEPTH)) begin
					if (k_q > pos_m1) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = k_q - 8'd1;
						state_d     = S_SHIFT;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = pos_m1;
						cmd.wr_data = req_q.value;
					end
				end else if (req_q.req_type == REQ_DELETE && pos_ok_other) begin
					if (k_q + 8'd1 < count_q) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = k_q + 8'd1;
						state_d     = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = k_q;
				cmd.wr_data = rd_data;
				state_d     = S_RD;
			end
			S_READ:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			k_q     <= 8'd0;
			req_q   <= '0;
			rsp_q   <= '0;
		end else begin
			if (state_q == S_IDLE && start) begin
				req_q <= req;
				k_q   <= (req.req_type == REQ_INSERT) ? count_q : req.position - 8'd1;
			end
			if (state_q == S_SHIFT)
				k_q <= (req_q.req_type == REQ_INSERT) ? k_q - 8'd1 : k_q + 8'd1;
			if (state_q == S_RD && state_d == S_DONE) begin
				rsp_q.read_value <= '0;
				rsp_q.status     <= ST_BADPOS;
				rsp_q.list_count <= count_q;
				if (req_q.req_type == REQ_INSERT && pos_ok_ins) begin
					if (count_q < 8'(DEPTH)) begin
						rsp_q.status     <= ST_OK;
						count_q          <= count_q + 8'd1;
						rsp_q.list_count <= count_q + 8'd1;
					end else
						rsp_q.status <= ST_FULL;
				end else if (req_q.req_type == REQ_DELETE && pos_ok_other) begin
					rsp_q.status     <= ST_OK;
					count_q          <= count_q - 8'd1;
					rsp_q.list_count <= count_q - 8'd1;
				end
			end
			if (state_q == S_READ) begin
				rsp_q.status     <= ST_OK;
				rsp_q.read_value <= rd_data;
				rsp_q.list_count <= count_q;
			end
		end
	end
endmodule

// File: sv/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks of the positional list, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_assert.svh"
module pli_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pli_pkg::pli_rsp_t result
);
	import pli_pkg::*;
	`PLID_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`PLID_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`PLID_ASSERT_NEXT(a_done_once, clk, arst_n, done, !done && !busy)
	`PLID_ASSERT_IMP(a_rd_zero, clk, arst_n, done && result.status != ST_OK, result.read_value == 0)
endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

// File: bench/positional_list_insert_delete_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_checker
// Watches the request and result beats of the positional list, predicts each
// result from its own copy of the list, and counts mismatches.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_checker #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pli_pkg::pli_req_t req,
	input  logic              busy,
	input  logic              done,
	input  pli_pkg::pli_rsp_t result,
	output int                fail_count,
	output int                pending
);
	import pli_pkg::*;

	logic signed [31:0] list_q [$];
	pli_rsp_t           expected_rsps [$];

	assign pending = expected_rsps.size();

	function automatic pli_rsp_t apply_request(pli_req_t r);
		pli_rsp_t rsp;
		int       cnt;
		int       pos;
		cnt = list_q.size();
		pos = r.position;
		rsp.status = ST_BADPOS;
		rsp.read_value = '0;
		case (r.req_type)
			REQ_INSERT: begin
				if (pos >= 1 && pos <= cnt + 1) begin
					if (cnt >= DEPTH) begin
						rsp.status = ST_FULL;
					end else begin
						list_q.insert(pos - 1, r.value);
						rsp.status = ST_OK;
					end
				end
			end
			REQ_DELETE: begin
				if (pos >= 1 && pos <= cnt) begin
					list_q.delete(pos - 1);
					rsp.status = ST_OK;
				end
			end
			REQ_READ: begin
				if (pos >= 1 && pos <= cnt) begin
					rsp.read_value = list_q[pos - 1];
					rsp.status = ST_OK;
				end
			end
			default: ;
		endcase
		rsp.list_count = 8'(list_q.size());
		return rsp;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		pli_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsps.size() == 0) begin
					report("unexpected result beat", 32'(result.status), 32'd0);
				end else begin
					want = expected_rsps.pop_front();
					if (result.status !== want.status)
						report("status", 32'(result.status), 32'(want.status));
					if (result.read_value !== want.read_value)
						report("read_value", result.read_value, want.read_value);
					if (result.list_count !== want.list_count)
						report("list_count", 32'(result.list_count), 32'(want.list_count));
				end
			end
			// Prediction after the check so a same-edge result pairs correctly.
			if (start && !busy)
				expected_rsps.push_back(apply_request(req));
		end
	end
endmodule

// File: bench/positional_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Drives directed and random insert, delete, read and unused-code beats into the list.
// ----------------------------------------------------------------------------
// The top only makes stimulus and gives the verdict; the checker beside the
// block predicts every result and counts mismatches. Random traffic keeps the
// list count wandering between empty and full so that every shift depth, the
// full case and the bad-position cases are all reached many times.
module positional_list_insert_delete_tb;
	import pli_pkg::*;

	localparam int DEPTH      = 16;
	localparam int NUM_RANDOM = 2000;
	localparam int IDLE_LIMIT = 2000;
	// Request code with no meaning; the block must reject it.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      start;
	pli_req_t  req;
	logic      busy;
	logic      done;
	pli_rsp_t  result;
	int        fail_count;
	int        pending;
	int        idle_cycles;
	// Local view of the list length, used only to aim positions and pick request kinds.
	int        model_len;

	positional_list_insert_delete #(.DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	positional_list_insert_delete_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog: cycles in which no beat moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Holds start for one request beat until it is accepted and leaves it high;
	// callers lower it before a gap.
	task automatic send_beat(logic [1:0] kind, logic [7:0] pos, logic [31:0] val);
		start <= 1'b1;
		req.req_type <= kind;
		req.position <= pos;
		req.value <= val;
		do @(posedge clk); while (busy);
		case (kind)
			REQ_INSERT: if (pos >= 1 && pos <= model_len + 1 && model_len < DEPTH)
				model_len++;
			REQ_DELETE: if (pos >= 1 && pos <= model_len)
				model_len--;
			default: ;
		endcase
	endtask

	task automatic random_gap();
		int gap;
		if ($urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_beat(bit steady);
		logic [1:0] kind;
		logic [7:0] pos;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			kind = REQ_UNUSED;
		else if (roll < 45)
			kind = (model_len < DEPTH || $urandom_range(0, 3) == 0) ? REQ_INSERT : REQ_DELETE;
		else if (roll < 75)
			kind = REQ_DELETE;
		else
			kind = REQ_READ;
		// Mostly legal positions, some off by one, some wild.
		roll = $urandom_range(0, 99);
		if (roll < 80)
			pos = 8'($urandom_range(1, model_len + 1));
		else if (roll < 90)
			pos = $urandom_range(0, 1) ? 8'd0 : 8'(model_len + 1);
		else
			pos = 8'($urandom_range(0, 255));
		if (steady && kind == REQ_DELETE && model_len < 4)
			kind = REQ_INSERT;
		send_beat(kind, pos, $urandom());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		model_len = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operations on the empty list, then fill, overflow, extremes.
		send_beat(REQ_READ, 8'd1, 32'h0);
		send_beat(REQ_DELETE, 8'd1, 32'h0);
		send_beat(REQ_INSERT, 8'd0, 32'h1234_5678);
		send_beat(REQ_INSERT, 8'd2, 32'h1);
		send_beat(REQ_INSERT, 8'd1, 32'h7fff_ffff);
		send_beat(REQ_INSERT, 8'd2, 32'h8000_0000);
		send_beat(REQ_INSERT, 8'd3, 32'hffff_ffff);
		send_beat(REQ_UNUSED, 8'd1, 32'h5555_5555);
		for (int i = 0; i < DEPTH - 3; i++)
			send_beat(REQ_INSERT, 8'd1, 32'(i) ^ 32'haaaa_aaaa);
		send_beat(REQ_INSERT, 8'd1, 32'h0);
		send_beat(REQ_INSERT, 8'(DEPTH + 2), 32'h0);
		send_beat(REQ_READ, 8'(DEPTH), 32'h0);
		send_beat(REQ_READ, 8'(DEPTH + 1), 32'h0);
		send_beat(REQ_READ, 8'd255, 32'h0);
		send_beat(REQ_DELETE, 8'(DEPTH), 32'h0);
		send_beat(REQ_DELETE, 8'd1, 32'h0);
		send_beat(REQ_INSERT, 8'(DEPTH - 1), 32'h0f0f_0f0f);

		// Pause the sender until every expected result has arrived.
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			// Stretches with no gaps at all alternate with gappy ones.
			if ((n / 200) % 2 == 1)
				random_gap();
			random_beat((n / 500) % 2 == 0);
			if (n == NUM_RANDOM / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
		end
		start <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (2 * DEPTH + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/pli_pkg.sv
sv/pli_mem.sv
sv/positional_list_insert_delete.sv
sv/pli_checker.sv
bench/positional_list_insert_delete_checker.sv
bench/positional_list_insert_delete_tb.sv
